>>> rtl/core/tlfq_pkg.sv
// Shared types and codes for the three-level feedback queue scheduler.
`timescale 1ns / 1ps

package tlfq_pkg;

    localparam int ID_W    = 8;
    localparam int TIME_W  = 7;
    localparam int CFG_W   = 7;
    localparam int CFG_IX_W = 2;
    localparam int FIN_W   = 16;

    typedef enum logic [2:0] {
        EV_ADMIT   = 3'd0,
        EV_REFUSE  = 3'd1,
        EV_FINISH  = 3'd2,
        EV_REQUEUE = 3'd3,
        EV_IDLE    = 3'd4,
        EV_HALT    = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        LVL_NONE   = 2'd0,
        LVL_FIRST  = 2'd1,
        LVL_SECOND = 2'd2,
        LVL_THIRD  = 2'd3
    } level_t;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_FIRST_QUANTUM  = 2'd0,
        CFG_SECOND_QUANTUM = 2'd1,
        CFG_FIRST_SHARE    = 2'd2,
        CFG_SECOND_SHARE   = 2'd3
    } cfg_idx_t;

    localparam logic CMD_ADMIT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [CFG_W-1:0] RST_FIRST_QUANTUM  = 7'd8;
    localparam logic [CFG_W-1:0] RST_SECOND_QUANTUM = 7'd16;
    localparam logic [CFG_W-1:0] RST_FIRST_SHARE    = 7'd50;
    localparam logic [CFG_W-1:0] RST_SECOND_SHARE   = 7'd80;

    // Queue entry: id in the upper bits, remaining time below.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] rem;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctl_t;

    typedef struct packed {
        logic empty;
        logic near_full;   // holds depth minus one or more
        logic full;
    } ring_stat_t;

    typedef struct packed {
        logic [CFG_W-1:0] first_quantum;
        logic [CFG_W-1:0] second_quantum;
        logic [CFG_W-1:0] first_share;
        logic [CFG_W-1:0] second_share;
    } cfg_t;

    typedef struct packed {
        event_t            ev;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] rem;
        level_t            level;
        logic [FIN_W-1:0]  finished;
    } result_t;

endpackage

>>> rtl/core/tlfq_ring.sv
// Ring FIFO of queue entries with a registered head read.
`timescale 1ns / 1ps

module tlfq_ring
    import tlfq_pkg::*;
#(
    parameter int DEPTH = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ring_ctl_t  ctl,
    input  entry_t     push_data,
    output entry_t     head_data,
    output ring_stat_t stat
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem [DEPTH];
    entry_t          head_data_reg;
    logic [IW-1:0]   head_reg, head_next, head_inc;
    logic [IW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;

    assign head_inc  = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_next = ctl.pop ? head_inc : head_reg;
    assign tail_next = ctl.push
                     ? ((tail_reg == IW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1)
                     : tail_reg;

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push && !ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop && !ctl.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Head read is registered; a write landing on the new head is forwarded.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (ctl.push && (tail_reg == head_next))
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign head_data      = head_data_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.near_full = (count_reg >= CW'(DEPTH - 1));
    assign stat.full      = (count_reg >= CW'(DEPTH));

endmodule

>>> rtl/core/tlfq_sched.sv
// Scheduling decision, finished counter and halt flag.
`timescale 1ns / 1ps

module tlfq_sched
    import tlfq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  cfg_t              cfg,
    input  logic              command,
    input  logic [ID_W-1:0]   process_id,
    input  logic [TIME_W-1:0] burst_time,
    input  logic [CFG_W-1:0]  pick,
    input  logic              demote_to_first,
    input  ring_stat_t        stat1,
    input  ring_stat_t        stat2,
    input  ring_stat_t        stat3,
    input  entry_t            head1,
    input  entry_t            head2,
    input  entry_t            head3,
    output ring_ctl_t         ctl1,
    output ring_ctl_t         ctl2,
    output ring_ctl_t         ctl3,
    output entry_t            push1_data,
    output entry_t            requeue_data,
    output result_t           result
);

    logic             halted_reg, halted_next;
    logic [FIN_W-1:0] finished_reg, finished_next;
    logic             fin_inc;
    ring_ctl_t        c1, c2, c3;
    logic             use1, use2, use3;
    entry_t           sel;
    logic [TIME_W-1:0] quantum, diff;
    logic             done;
    result_t          res;

    always_comb
    begin
        use1 = (pick != '0) && (pick <= cfg.first_share) && !stat1.empty && !stat2.full;
        use2 = !use1 && (pick > cfg.first_share) && (pick <= cfg.second_share)
               && !stat2.empty;
        use3 = !use1 && !use2 && !stat3.empty;

        sel     = head3;
        quantum = '0;
        if (use1)
        begin
            sel     = head1;
            quantum = cfg.first_quantum;
        end
        else if (use2)
        begin
            sel     = head2;
            quantum = cfg.second_quantum;
        end
        diff = sel.rem - quantum;
        done = use3 || (sel.rem <= quantum);
    end

    always_comb
    begin
        c1          = '0;
        c2          = '0;
        c3          = '0;
        halted_next = halted_reg;
        fin_inc     = 1'b0;
        res         = '{ev: EV_IDLE, id: '0, rem: '0, level: LVL_NONE, finished: '0};
        push1_data  = '{id: process_id, rem: burst_time};
        requeue_data = '{id: sel.id, rem: diff};

        if (halted_reg)
        begin
            res.ev = EV_HALT;
        end
        else if (command == CMD_ADMIT)
        begin
            if (!stat1.near_full)
            begin
                c1.push = 1'b1;
                res     = '{ev: EV_ADMIT, id: process_id, rem: burst_time,
                            level: LVL_FIRST, finished: '0};
            end
            else
            begin
                res.ev = EV_REFUSE;
            end
        end
        else if (use1 || use2 || use3)
        begin
            c1.pop = use1;
            c2.pop = use2;
            c3.pop = use3;
            res.id = sel.id;
            if (done)
            begin
                fin_inc = 1'b1;
                res.ev  = EV_FINISH;
            end
            else
            begin
                res.ev  = EV_REQUEUE;
                res.rem = diff;
                push1_data = requeue_data;
                if (use1)
                begin
                    c2.push   = 1'b1;
                    res.level = LVL_SECOND;
                end
                else if (demote_to_first && !stat1.full)
                begin
                    c1.push   = 1'b1;
                    res.level = LVL_FIRST;
                end
                else if (!stat3.full)
                begin
                    c3.push   = 1'b1;
                    res.level = LVL_THIRD;
                end
                else
                begin
                    // level three overflow: process is lost, block stops
                    halted_next = 1'b1;
                    res.ev      = EV_HALT;
                end
            end
        end

        finished_next = (fin_inc && (finished_reg != '1)) ? finished_reg + 1'b1
                                                          : finished_reg;
        res.finished  = finished_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg   <= 1'b0;
            finished_reg <= '0;
        end
        else if (fire)
        begin
            halted_reg   <= halted_next;
            finished_reg <= finished_next;
        end
    end

    assign ctl1   = fire ? c1 : '0;
    assign ctl2   = fire ? c2 : '0;
    assign ctl3   = fire ? c3 : '0;
    assign result = res;

endmodule

>>> rtl/core/three_level_feedback_queue_scheduler.sv
// Top level of the three-level feedback queue scheduler.
`timescale 1ns / 1ps

// Takes one admit or tick item per clock while in_stall is low and returns
// one result per item. An item is captured in an input register, decided
// against the queue state left by the item before it, and presented from a
// result register; the decision waits while the result register is held by
// out_stall. The sustained rate is one item per cycle while out_stall is low.
// The input stalls only while the input register is full and the result
// register is held by out_stall. The three queues are
// register rings whose head entries are read into a register; their sizes
// are FIRST_DEPTH, SECOND_DEPTH and THIRD_DEPTH. Queue contents need no
// clearing after reset. Configuration writes are taken at any edge with
// cfg_write high and should only be made while no item is in flight.
module three_level_feedback_queue_scheduler
    import tlfq_pkg::*;
#(
    parameter int FIRST_DEPTH  = 10,
    parameter int SECOND_DEPTH = 20,
    parameter int THIRD_DEPTH  = 30
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [CFG_IX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [ID_W-1:0]     process_id,
    input  logic [TIME_W-1:0]   burst_time,
    input  logic [CFG_W-1:0]    pick,
    input  logic                demote_to_first,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          event_res,
    output logic [ID_W-1:0]     event_process_id,
    output logic [TIME_W-1:0]   remaining_time,
    output logic [1:0]          destination_level,
    output logic [FIN_W-1:0]    finished_total
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic              command_reg;
    logic [ID_W-1:0]   process_id_reg;
    logic [TIME_W-1:0] burst_time_reg;
    logic [CFG_W-1:0]  pick_reg;
    logic              demote_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           result;
    logic              advance, in_xfer;
    ring_ctl_t         ctl1, ctl2, ctl3;
    ring_stat_t        stat1, stat2, stat3;
    entry_t            head1, head2, head3;
    entry_t            push1_data, requeue_data;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_quantum  <= RST_FIRST_QUANTUM;
            cfg_reg.second_quantum <= RST_SECOND_QUANTUM;
            cfg_reg.first_share    <= RST_FIRST_SHARE;
            cfg_reg.second_share   <= RST_SECOND_SHARE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FIRST_QUANTUM:  cfg_reg.first_quantum  <= cfg_data;
                CFG_SECOND_QUANTUM: cfg_reg.second_quantum <= cfg_data;
                CFG_FIRST_SHARE:    cfg_reg.first_share    <= cfg_data;
                CFG_SECOND_SHARE:   cfg_reg.second_share   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            command_reg    <= command;
            process_id_reg <= process_id;
            burst_time_reg <= burst_time;
            pick_reg       <= pick;
            demote_reg     <= demote_to_first;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    tlfq_ring #(.DEPTH(FIRST_DEPTH)) u_ring1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl1),
        .push_data (push1_data),
        .head_data (head1),
        .stat      (stat1)
    );

    tlfq_ring #(.DEPTH(SECOND_DEPTH)) u_ring2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl2),
        .push_data (requeue_data),
        .head_data (head2),
        .stat      (stat2)
    );

    tlfq_ring #(.DEPTH(THIRD_DEPTH)) u_ring3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl3),
        .push_data (requeue_data),
        .head_data (head3),
        .stat      (stat3)
    );

    tlfq_sched u_sched (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (advance),
        .cfg             (cfg_reg),
        .command         (command_reg),
        .process_id      (process_id_reg),
        .burst_time      (burst_time_reg),
        .pick            (pick_reg),
        .demote_to_first (demote_reg),
        .stat1           (stat1),
        .stat2           (stat2),
        .stat3           (stat3),
        .head1           (head1),
        .head2           (head2),
        .head3           (head3),
        .ctl1            (ctl1),
        .ctl2            (ctl2),
        .ctl3            (ctl3),
        .push1_data      (push1_data),
        .requeue_data    (requeue_data),
        .result          (result)
    );

    assign out_valid         = out_valid_reg;
    assign event_res         = out_reg.ev;
    assign event_process_id  = out_reg.id;
    assign remaining_time    = out_reg.rem;
    assign destination_level = out_reg.level;
    assign finished_total    = out_reg.finished;

    // at most one queue gives up its head per item
    a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl1.pop, ctl2.pop, ctl3.pop}))
        else $error("more than one queue popped");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (!(ctl1.pop && stat1.empty)) && (!(ctl2.pop && stat2.empty))
        && (!(ctl3.pop && stat3.empty)))
        else $error("pop from empty queue");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (!(ctl1.push && stat1.full)) && (!(ctl2.push && stat2.full))
        && (!(ctl3.push && stat3.full)))
        else $error("push into full queue");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

endmodule
